// ----- hw/rtl/ssc_pkg.sv -----
// shared constants and types for the switching sequence checker
`timescale 1ns / 1ps

package ssc_pkg;

  // default sample width and first sample of the open check
  localparam int SAMPLE_BITS_DEF      = 12;
  localparam int OPEN_CHECK_START_DEF = 4;

  // register field widths
  localparam int THRESH_W = 11;
  localparam int WLEN_W   = 7;
  localparam int CNT_W    = 7;
  localparam int STATE_W  = 2;

  // register reset values
  localparam logic [THRESH_W-1:0] THRESH_RST = THRESH_W'(70);
  localparam logic [WLEN_W-1:0]   WLEN_RST   = WLEN_W'(100);

  // configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam logic REG_THRESHOLD  = 1'b0;
  localparam logic REG_WINDOW_LEN = 1'b1;

  // line state codes
  typedef logic [STATE_W-1:0] line_state_t;
  localparam line_state_t LS_OPEN    = 2'd0;
  localparam line_state_t LS_IDLE    = 2'd1;
  localparam line_state_t LS_PASSED  = 2'd2;
  localparam line_state_t LS_CLOSED  = 2'd3;

endpackage

// ----- hw/rtl/ssc_if.sv -----
// valid/ready channel interfaces for samples and results
`timescale 1ns / 1ps

interface ssc_in_if #(
  parameter int SAMPLE_BITS = ssc_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          show_request;

  modport source (output valid, output sample, output show_request, input ready);
  modport sink   (input valid, input sample, input show_request, output ready);
endinterface

interface ssc_out_if;
  logic                        valid;
  logic                        ready;
  logic [ssc_pkg::STATE_W-1:0] line_state;
  logic                        passed;
  logic                        show_flag;

  modport source (output valid, output line_state, output passed, output show_flag,
                  input ready);
  modport sink   (input valid, input line_state, input passed, input show_flag,
                  output ready);
endinterface

// ----- hw/rtl/switching_sequence_checker_top.sv -----
// switching sequence checker: sample classification, window checks and pass latch
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+---------------------------------
//   in_ch    | sink      | valid/ready           | sample, show_request
//   out_ch   | source    | valid/ready           | line_state, passed, show_flag
//   apb      | slave     | psel/penable, pready=1| threshold @0x0, window_length @0x4
//
// one sample per cycle sustained while out_ch does not stall the result
// the input register feeds one step of compare and counter logic into the result register
// synchronous active-low reset clears the valid bits and resets check state and config registers
// a stalled result holds the result register; the input register takes one more sample if it is
// empty, then in_ch.ready drops until the result is taken
`timescale 1ns / 1ps

module switching_sequence_checker_top #(
  parameter int SAMPLE_BITS      = ssc_pkg::SAMPLE_BITS_DEF,
  parameter int OPEN_CHECK_START = ssc_pkg::OPEN_CHECK_START_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  ssc_in_if.sink                           in_ch,
  ssc_out_if.source                        out_ch,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ssc_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [ssc_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [ssc_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import ssc_pkg::*;

  // compare width holds the sample and the negated threshold
  localparam int CMP_W = ((SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W) + 2;
  localparam logic [CNT_W-1:0] OPEN_START = CNT_W'(OPEN_CHECK_START);

  // configuration registers
  logic [THRESH_W-1:0] threshold_r;
  logic [WLEN_W-1:0]   window_len_r;
  logic                cfg_wr;
  logic                reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r  <= THRESH_RST;
      window_len_r <= WLEN_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_THRESHOLD:  threshold_r  <= pwdata[THRESH_W-1:0];
        REG_WINDOW_LEN: window_len_r <= pwdata[WLEN_W-1:0];
        default:        ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_sel)
      REG_THRESHOLD:  prdata = CFG_DATA_W'(threshold_r);
      REG_WINDOW_LEN: prdata = CFG_DATA_W'(window_len_r);
      default:        prdata = '0;
    endcase
  end

  // pipeline control
  logic in_vld_r;
  logic out_vld_r;
  logic adv;
  logic in_xfer;

  assign adv          = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready  = !in_vld_r || adv;
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ch.ready) in_vld_r <= in_ch.valid;
      if (adv) out_vld_r <= 1'b1;
      else if (out_ch.ready) out_vld_r <= 1'b0;
    end
  end

  // input register
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic                          show_req_r;

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      sample_r   <= in_ch.sample;
      show_req_r <= in_ch.show_request;
    end
  end

  // check state
  line_state_t      state_r,      state_nxt;
  logic             first_pend_r, first_pend_nxt;
  logic             low_seen_r,   low_seen_nxt;
  logic             armed_r,      armed_nxt;
  logic [CNT_W-1:0] cnt_r,        cnt_nxt;
  logic             first_hi_r,   first_hi_nxt;
  logic             closed_r,     closed_nxt;
  logic             opened_r,     opened_nxt;
  logic             timed_r,      timed_nxt;
  logic             pass_r,       pass_nxt;
  logic             disp_r,       disp_nxt;

  // sample classification with strict compares
  logic signed [CMP_W-1:0] s_ext;
  logic signed [CMP_W-1:0] t_pos;
  logic signed [CMP_W-1:0] t_neg;
  logic                    is_low, is_high, is_neutral;
  logic [CNT_W-1:0]        cnt_inc;

  assign s_ext      = CMP_W'(sample_r);
  assign t_pos      = $signed({{(CMP_W-THRESH_W){1'b0}}, threshold_r});
  assign t_neg      = -t_pos;
  assign is_low     = s_ext < t_neg;
  assign is_high    = s_ext > t_pos;
  assign is_neutral = (s_ext > t_neg) && (s_ext < t_pos);
  assign cnt_inc    = cnt_r + CNT_W'(1);

  // one step of the sequence check
  always_comb begin
    state_nxt      = state_r;
    first_pend_nxt = first_pend_r;
    low_seen_nxt   = low_seen_r;
    armed_nxt      = armed_r;
    cnt_nxt        = cnt_r;
    first_hi_nxt   = first_hi_r;
    closed_nxt     = closed_r;
    opened_nxt     = opened_r;
    timed_nxt      = timed_r;
    pass_nxt       = pass_r;
    disp_nxt       = disp_r;

    if (is_neutral) state_nxt = LS_IDLE;
    if (is_low) begin
      state_nxt    = LS_OPEN;
      low_seen_nxt = 1'b1;
    end
    if (is_high && first_pend_r) begin
      state_nxt      = LS_IDLE;
      first_pend_nxt = 1'b0;
    end
    // low-to-high crossing arms the window
    if (low_seen_r && is_high) armed_nxt = 1'b1;

    if (armed_nxt) begin
      cnt_nxt = cnt_inc;
      if (cnt_inc == CNT_W'(1)) first_hi_nxt = is_high;
      if (cnt_inc == CNT_W'(2)) begin
        if (first_hi_r && is_high) begin
          closed_nxt = 1'b1;
          state_nxt  = LS_CLOSED;
        end else begin
          state_nxt = LS_IDLE;
          cnt_nxt   = '0;
        end
      end
      if (cnt_inc >= OPEN_START) begin
        if (cnt_inc < window_len_r) begin
          if (is_low) opened_nxt = 1'b1;
        end else begin
          // window end
          timed_nxt    = 1'b1;
          state_nxt    = LS_IDLE;
          cnt_nxt      = '0;
          low_seen_nxt = is_low;
          armed_nxt    = 1'b0;
        end
      end
    end

    // all marks held: latch the pass
    if (closed_nxt && opened_nxt && timed_nxt) begin
      state_nxt = LS_PASSED;
      pass_nxt  = 1'b1;
      disp_nxt  = 1'b0;
    end

    if (show_req_r) disp_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= LS_OPEN;
      first_pend_r <= 1'b1;
      low_seen_r   <= 1'b0;
      armed_r      <= 1'b0;
      cnt_r        <= '0;
      first_hi_r   <= 1'b0;
      closed_r     <= 1'b0;
      opened_r     <= 1'b0;
      timed_r      <= 1'b0;
      pass_r       <= 1'b0;
      disp_r       <= 1'b1;
    end else if (adv) begin
      state_r      <= state_nxt;
      first_pend_r <= first_pend_nxt;
      low_seen_r   <= low_seen_nxt;
      armed_r      <= armed_nxt;
      cnt_r        <= cnt_nxt;
      first_hi_r   <= first_hi_nxt;
      closed_r     <= closed_nxt;
      opened_r     <= opened_nxt;
      timed_r      <= timed_nxt;
      pass_r       <= pass_nxt;
      disp_r       <= disp_nxt;
    end
  end

  // result register
  line_state_t line_state_r;
  logic        passed_r;
  logic        show_flag_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      line_state_r <= state_nxt;
      passed_r     <= pass_nxt;
      show_flag_r  <= disp_nxt;
    end
  end

  assign out_ch.line_state = line_state_r;
  assign out_ch.passed     = passed_r;
  assign out_ch.show_flag  = show_flag_r;

endmodule
